### hw/rtl/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared types and constants of the min/max bucket decimator.
// ----------------------------------------------------------------------------
package mmbd_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int INDEX_WIDTH  = 32;
  localparam int SIZE_WIDTH   = 17;
  localparam int POINTS       = 4;

  localparam logic [SIZE_WIDTH-1:0] BUCKET_MIN   = SIZE_WIDTH'(2);
  localparam logic [SIZE_WIDTH-1:0] BUCKET_MAX   = SIZE_WIDTH'(65536);
  localparam logic [SIZE_WIDTH-1:0] BUCKET_RESET = SIZE_WIDTH'(64);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic                          sample_valid;
    logic                          curve_end;
  } in_item_t;

  typedef struct packed {
    logic        [INDEX_WIDTH-1:0] point_index;
    logic signed [VALUE_WIDTH-1:0] point_value;
    logic                          bucket_last;
    logic                          run_last;
  } out_item_t;

  typedef struct packed {
    logic        [INDEX_WIDTH-1:0] index;
    logic signed [VALUE_WIDTH-1:0] value;
  } point_t;

  // Closed bucket: candidate points in arrival order, keep mask drops repeats.
  typedef struct packed {
    point_t [POINTS-1:0] pts;
    logic   [POINTS-1:0] keep;
    logic                run_last;
  } bucket_rec_t;

endpackage

### hw/rtl/mmbd_accum.sv
// ----------------------------------------------------------------------------
// mmbd_accum
// Bucket tracker: keeps first, min, max and latest point of the open bucket
// and registers a bucket request when the bucket closes.
// ----------------------------------------------------------------------------
module mmbd_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mmbd_pkg::SIZE_WIDTH-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mmbd_pkg::in_item_t                   in_data,
  output logic                                 rec_valid,
  output mmbd_pkg::bucket_rec_t                rec,
  input  logic                                 take
);

  logic [mmbd_pkg::SIZE_WIDTH-1:0]         bucket_size;
  logic [mmbd_pkg::INDEX_WIDTH-1:0]        sample_counter;
  logic [mmbd_pkg::SIZE_WIDTH-1:0]         fill;
  logic [mmbd_pkg::INDEX_WIDTH-1:0]        first_index, min_index, max_index, latest_index;
  logic signed [mmbd_pkg::VALUE_WIDTH-1:0] first_value, min_value, max_value, latest_value;
  logic [mmbd_pkg::SIZE_WIDTH-1:0]         min_pos, max_pos;

  logic [mmbd_pkg::SIZE_WIDTH-1:0]         fill_next;
  logic [mmbd_pkg::INDEX_WIDTH-1:0]        first_index_next, min_index_next;
  logic [mmbd_pkg::INDEX_WIDTH-1:0]        max_index_next, latest_index_next;
  logic signed [mmbd_pkg::VALUE_WIDTH-1:0] first_value_next, min_value_next;
  logic signed [mmbd_pkg::VALUE_WIDTH-1:0] max_value_next, latest_value_next;
  logic [mmbd_pkg::SIZE_WIDTH-1:0]         min_pos_next, max_pos_next;

  logic [mmbd_pkg::SIZE_WIDTH-1:0]         size_eff;
  logic [mmbd_pkg::SIZE_WIDTH-1:0]         last_pos, lo_pos, hi_pos;
  logic                                    accept, close;
  mmbd_pkg::bucket_rec_t                   rec_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = rec_valid && !take;

  always_comb begin
    if (bucket_size < mmbd_pkg::BUCKET_MIN) begin
      size_eff = mmbd_pkg::BUCKET_MIN;
    end else if (bucket_size > mmbd_pkg::BUCKET_MAX) begin
      size_eff = mmbd_pkg::BUCKET_MAX;
    end else begin
      size_eff = bucket_size;
    end
  end

  always_comb begin
    fill_next         = fill;
    first_index_next  = first_index;
    first_value_next  = first_value;
    min_index_next    = min_index;
    min_value_next    = min_value;
    min_pos_next      = min_pos;
    max_index_next    = max_index;
    max_value_next    = max_value;
    max_pos_next      = max_pos;
    latest_index_next = latest_index;
    latest_value_next = latest_value;
    if (in_data.sample_valid) begin
      if (fill == '0) begin
        first_index_next = sample_counter;
        first_value_next = in_data.sample_value;
        min_index_next   = sample_counter;
        min_value_next   = in_data.sample_value;
        min_pos_next     = '0;
        max_index_next   = sample_counter;
        max_value_next   = in_data.sample_value;
        max_pos_next     = '0;
      end else begin
        // strict compares: ties keep the earliest point
        if (in_data.sample_value < min_value) begin
          min_index_next = sample_counter;
          min_value_next = in_data.sample_value;
          min_pos_next   = fill;
        end
        if (in_data.sample_value > max_value) begin
          max_index_next = sample_counter;
          max_value_next = in_data.sample_value;
          max_pos_next   = fill;
        end
      end
      latest_index_next = sample_counter;
      latest_value_next = in_data.sample_value;
      fill_next         = fill + mmbd_pkg::SIZE_WIDTH'(1);
      close             = (fill_next >= size_eff) || in_data.curve_end;
    end else begin
      close = (fill != '0);
    end

    last_pos = fill_next - mmbd_pkg::SIZE_WIDTH'(1);

    // order the middle pair by arrival
    if (min_pos_next <= max_pos_next) begin
      lo_pos          = min_pos_next;
      hi_pos          = max_pos_next;
      rec_next.pts[1] = '{index: min_index_next, value: min_value_next};
      rec_next.pts[2] = '{index: max_index_next, value: max_value_next};
    end else begin
      lo_pos          = max_pos_next;
      hi_pos          = min_pos_next;
      rec_next.pts[1] = '{index: max_index_next, value: max_value_next};
      rec_next.pts[2] = '{index: min_index_next, value: min_value_next};
    end
    rec_next.pts[0]  = '{index: first_index_next, value: first_value_next};
    rec_next.pts[3]  = '{index: latest_index_next, value: latest_value_next};
    rec_next.keep[0] = 1'b1;
    rec_next.keep[1] = (lo_pos != '0);
    rec_next.keep[2] = (hi_pos != lo_pos);
    rec_next.keep[3] = (last_pos != hi_pos);
    rec_next.run_last = in_data.sample_valid ? in_data.curve_end : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_size    <= mmbd_pkg::BUCKET_RESET;
      sample_counter <= '0;
      fill           <= '0;
      rec_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        bucket_size <= cfg_data;
      end
      if (accept) begin
        sample_counter <= in_data.curve_end ? '0
                                            : sample_counter + mmbd_pkg::INDEX_WIDTH'(1);
        fill           <= close ? '0 : fill_next;
      end
      if (accept && close) begin
        rec_valid <= 1'b1;
      end else if (take) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_index  <= first_index_next;
      first_value  <= first_value_next;
      min_index    <= min_index_next;
      min_value    <= min_value_next;
      min_pos      <= min_pos_next;
      max_index    <= max_index_next;
      max_value    <= max_value_next;
      max_pos      <= max_pos_next;
      latest_index <= latest_index_next;
      latest_value <= latest_value_next;
    end
    if (accept && close) begin
      rec <= rec_next;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill < mmbd_pkg::BUCKET_MAX)
    else $error("open bucket holds a full bucket or more");

  a_first_kept: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> rec.keep[0])
    else $error("bucket request without its first point");

  a_close_posts: assert property (@(posedge clk) disable iff (rst)
    accept && close |=> rec_valid)
    else $error("closed bucket was not posted");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rec_valid && !take |=> rec_valid && $stable(rec))
    else $error("pending bucket request lost or changed");

endmodule

### hw/rtl/mmbd_drain.sv
// ----------------------------------------------------------------------------
// mmbd_drain
// Point serializer: sends the kept points of one bucket, one per cycle when
// out_stall is low, from registers while the next bucket request waits.
// ----------------------------------------------------------------------------
module mmbd_drain (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             rec_valid,
  input  mmbd_pkg::bucket_rec_t            rec,
  output logic                             take,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mmbd_pkg::out_item_t              out_data
);

  logic [mmbd_pkg::POINTS-1:0]  mask;
  mmbd_pkg::point_t [mmbd_pkg::POINTS-1:0] pts;
  logic                         run_last;
  logic                         done;
  mmbd_pkg::point_t             cur;

  assign out_valid = |mask;
  assign done      = (mask == '0) || ($onehot(mask) && !out_stall);
  assign take      = rec_valid && done;

  always_comb begin
    if (mask[0]) begin
      cur = pts[0];
    end else if (mask[1]) begin
      cur = pts[1];
    end else if (mask[2]) begin
      cur = pts[2];
    end else begin
      cur = pts[3];
    end
    out_data.point_index = cur.index;
    out_data.point_value = cur.value;
    out_data.bucket_last = $onehot(mask);
    out_data.run_last    = run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (take) begin
      mask <= rec.keep;
    end else if (out_valid && !out_stall) begin
      // drop the point just sent
      mask <= mask & (mask - mmbd_pkg::POINTS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pts      <= rec.pts;
      run_last <= rec.run_last;
    end
  end

  a_load: assert property (@(posedge clk) disable iff (rst)
    take |=> mask == $past(rec.keep))
    else $error("bucket request not loaded into the drain");

  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !take |=>
      $countones(mask) == $countones($past(mask)) - 1)
    else $error("drain skipped or repeated a point");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |-> !out_valid || !out_stall)
    else $error("drain reloaded while a point is stalled");

endmodule

### hw/rtl/min_max_bucket_decimator_top.sv
// ----------------------------------------------------------------------------
// min_max_bucket_decimator_top
// Min/max bucket decimator. One curve sample is taken per cycle while in_stall
// is low. Runs of valid samples are cut into buckets of bucket_size samples
// (clamped to 2..65536); a bucket closes when full, on an invalid sample or on
// curve end, and then gives 1 to 4 points (first, min, max, latest in arrival
// order, repeats dropped), sent one per cycle while out_stall is low. A sample
// enters in the cycle it is offered unless a closed bucket is still waiting
// behind the one being sent; the single-point output drain sets that limit. A
// closing bucket is registered as a request, then loaded into the drain.
// ----------------------------------------------------------------------------
module min_max_bucket_decimator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mmbd_pkg::SIZE_WIDTH-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mmbd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mmbd_pkg::out_item_t              out_data
);

  logic                  rec_valid;
  logic                  take;
  mmbd_pkg::bucket_rec_t rec;

  mmbd_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .rec_valid (rec_valid),
    .rec       (rec),
    .take      (take)
  );

  mmbd_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec       (rec),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
